// File: src/mnps_pkg.sv
// mnps_pkg: shared types, constants and address helper for the note stack
// used by mono_note_priority_stack, mnps_checker and the testbench
`default_nettype none

package mnps_pkg;

   // number of held notes kept before the oldest one is dropped
   localparam int STACK_DEPTH = 16;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int FIELD_W     = 7;

   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [CNT_W-1:0]   cnt_type;

   typedef enum logic [1:0] {
      ACT_TRIGGER = 2'd0,
      ACT_SLIDE   = 2'd1,
      ACT_RELEASE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // one stored note
   typedef struct packed {
      field_type key;
      field_type vel;
      field_type det;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // one result
   typedef struct packed {
      action_type action;
      field_type  key;
      field_type  vel;
      field_type  det;
      logic       reset_osc;
      logic       dropped;
   } result_type;

   // physical slot of a logical stack position in the circular buffer
   function automatic ptr_type phys_addr(input ptr_type base, input ptr_type idx);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, idx};
      if (sum >= (PTR_W+1)'(STACK_DEPTH)) begin
         sum = sum - (PTR_W+1)'(STACK_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/mnps_ram.sv
// mnps_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module mnps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/mono_note_priority_stack.sv
// mono_note_priority_stack: last-note-priority stack of held notes in a circular ram
// depends on mnps_pkg and mnps_ram
// a note-on or an empty-stack note-off passes from idle to the done state and then to the
// output register; other note-offs first pass the scan state, one ram read per held entry
// throughput: one request at a time; the next request is taken once the result is
// staged, even while the previous result still waits on rsp_stall
// reset: synchronous, clears the stack count and pointer; ram contents are not cleared
`default_nettype none

module mono_note_priority_stack (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire mnps_pkg::field_type        req_note_key,
   input  wire mnps_pkg::field_type        req_note_velocity,
   input  wire mnps_pkg::field_type        req_note_detune,
   input  wire logic                       req_envelope_idle,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_voice_action,
   output mnps_pkg::field_type             rsp_target_key,
   output mnps_pkg::field_type             rsp_target_velocity,
   output mnps_pkg::field_type             rsp_target_detune,
   output logic                            rsp_reset_oscillators,
   output logic                            rsp_oldest_dropped
);

   import mnps_pkg::*;

   state_type  state_ff, state_in;
   ptr_type    base_ff, base_in;
   cnt_type    count_ff, count_in;
   cnt_type    rd_idx_ff, rd_idx_in;
   cnt_type    kept_ff, kept_in;
   logic       rd_vld_ff, rd_vld_in;
   field_type  key_ff;
   entry_type  top_ff;
   result_type pend_ff, pend_in;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       req_fire;
   logic       is_push;
   logic       full;
   logic       out_free;
   logic       scan_end;
   logic       keep_entry;

   logic       ram_wr_en;
   ptr_type    ram_wr_addr;
   entry_type  ram_wr_data;
   logic       ram_rd_en;
   ptr_type    ram_rd_addr;
   entry_type  ram_rd_data;

   assign req_fire   = req_valid && !req_stall;
   assign is_push    = (req_note_velocity != '0);
   assign full       = (count_ff == CNT_W'(STACK_DEPTH));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_end   = (rd_idx_ff == count_ff) && !rd_vld_ff;
   assign keep_entry = rd_vld_ff && (ram_rd_data.key != key_ff);

   // held note storage
   mnps_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(STACK_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_push || count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ram control and request stall
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      ram_wr_en   = 1'b0;
      ram_wr_addr = phys_addr(base_ff, kept_ff[PTR_W-1:0]);
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = phys_addr(base_ff, rd_idx_ff[PTR_W-1:0]);
      unique case (state_ff)
         ST_IDLE: begin
            // push writes above the top, or over the oldest slot when full
            ram_wr_en   = req_fire && is_push;
            ram_wr_addr = full ? base_ff : phys_addr(base_ff, count_ff[PTR_W-1:0]);
            ram_wr_data = '{key: req_note_key, vel: req_note_velocity,
                            det: req_note_detune};
         end
         ST_SCAN: begin
            // compaction: read ahead, write back kept entries
            ram_rd_en = (rd_idx_ff < count_ff);
            ram_wr_en = keep_entry;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // next values of the stack pointers and the pending result
   always_comb begin
      base_in      = base_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      kept_in      = kept_ff;
      rd_vld_in    = 1'b0;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_idx_in = '0;
            kept_in   = '0;
            if (req_fire && is_push) begin
               if (full) begin
                  base_in = (base_ff == PTR_W'(STACK_DEPTH - 1)) ? '0 : base_ff + 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               pend_in.action    = (count_ff == '0) ? ACT_TRIGGER : ACT_SLIDE;
               pend_in.key       = req_note_key;
               pend_in.vel       = req_note_velocity;
               pend_in.det       = req_note_detune;
               pend_in.reset_osc = (count_ff == '0) && req_envelope_idle;
               pend_in.dropped   = full;
            end else if (req_fire) begin
               // release on an empty stack answers at once
               pend_in = '{action: ACT_RELEASE, key: req_note_key, vel: '0, det: '0,
                           reset_osc: 1'b0, dropped: 1'b0};
            end
         end
         ST_SCAN: begin
            if (ram_rd_en) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (keep_entry) begin
               kept_in = kept_ff + 1'b1;
            end
            if (scan_end) begin
               count_in = kept_ff;
               if (kept_ff == '0) begin
                  pend_in = '{action: ACT_RELEASE, key: key_ff, vel: '0, det: '0,
                              reset_osc: 1'b0, dropped: 1'b0};
               end else begin
                  pend_in = '{action: ACT_SLIDE, key: top_ff.key, vel: top_ff.vel,
                              det: top_ff.det, reset_osc: 1'b0, dropped: 1'b0};
               end
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
      // output register
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         kept_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         kept_ff      <= kept_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (state_ff == ST_IDLE && req_fire) begin
         key_ff <= req_note_key;
      end
      if (keep_entry) begin
         top_ff <= ram_rd_data;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_voice_action      = rsp_ff.action;
   assign rsp_target_key        = rsp_ff.key;
   assign rsp_target_velocity   = rsp_ff.vel;
   assign rsp_target_detune     = rsp_ff.det;
   assign rsp_reset_oscillators = rsp_ff.reset_osc;
   assign rsp_oldest_dropped    = rsp_ff.dropped;

endmodule

`default_nettype wire

// File: src/mnps_checker.sv
// mnps_checker: port-level assertions for mono_note_priority_stack, bound to the top
// depends on mnps_pkg
`default_nettype none

module mnps_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [1:0]          rsp_voice_action,
   input wire mnps_pkg::field_type rsp_target_velocity,
   input wire mnps_pkg::field_type rsp_target_detune,
   input wire logic                rsp_reset_oscillators,
   input wire logic                rsp_oldest_dropped
);

   import mnps_pkg::*;

   // a stalled result stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // the block is busy in the cycle after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // a release carries no velocity, detune or flags
   a_release_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_voice_action == ACT_RELEASE |->
         rsp_target_velocity == '0 && rsp_target_detune == '0 &&
         !rsp_reset_oscillators && !rsp_oldest_dropped)
      else $error("release result with stray fields");

   // oscillator reset only on trigger
   a_reset_on_trigger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reset_oscillators |-> rsp_voice_action == ACT_TRIGGER)
      else $error("oscillator reset outside trigger");

   // overflow only comes from a note-on that slides
   a_drop_on_slide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_oldest_dropped |->
         rsp_voice_action == ACT_SLIDE && rsp_target_velocity != '0)
      else $error("overflow flag on wrong result");

endmodule

bind mono_note_priority_stack mnps_checker u_mnps_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_voice_action     (rsp_voice_action),
   .rsp_target_velocity  (rsp_target_velocity),
   .rsp_target_detune    (rsp_target_detune),
   .rsp_reset_oscillators(rsp_reset_oscillators),
   .rsp_oldest_dropped   (rsp_oldest_dropped)
);

`default_nettype wire

// File: verif/tb_mono_note_priority_stack.sv
// tb_mono_note_priority_stack: self-checking testbench for the last-note-priority note stack
// depends on mnps_pkg and the mono_note_priority_stack rtl; holds its own stack predictor
`default_nettype none

module tb_mono_note_priority_stack;
   import mnps_pkg::*;

   localparam int RANDOM_ITEMS = 1825;
   localparam int TAIL_ITEMS   = 200;
   localparam int WATCHDOG_MAX = 1000;
   localparam int DRAIN_CYCLES = 25;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   field_type req_note_key = '0;
   field_type req_note_velocity = '0;
   field_type req_note_detune = '0;
   logic      req_envelope_idle = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic [1:0] rsp_voice_action;
   field_type rsp_target_key;
   field_type rsp_target_velocity;
   field_type rsp_target_detune;
   logic      rsp_reset_oscillators;
   logic      rsp_oldest_dropped;

   // predictor state: index 0 is the oldest held note
   entry_type  note_stack [STACK_DEPTH];
   int         stack_fill = 0;
   result_type pending_voices [$];
   bit         failed = 1'b0;
   bit         idle_enable = 1'b1;
   int         stall_left = 0;
   int         quiet_cycles = 0;
   // requests accepted so far
   int         sent_items = 0;

   mono_note_priority_stack dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_note_key          (req_note_key),
      .req_note_velocity     (req_note_velocity),
      .req_note_detune       (req_note_detune),
      .req_envelope_idle     (req_envelope_idle),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_voice_action      (rsp_voice_action),
      .rsp_target_key        (rsp_target_key),
      .rsp_target_velocity   (rsp_target_velocity),
      .rsp_target_detune     (rsp_target_detune),
      .rsp_reset_oscillators (rsp_reset_oscillators),
      .rsp_oldest_dropped    (rsp_oldest_dropped)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // apply one note event to the predicted stack and return the voice action it causes
   function automatic result_type predict_voice(input field_type key, input field_type vel,
                                                input field_type det, input logic env_idle);
      result_type voice;
      int kept;
      voice = '0;
      if (vel != '0) begin
         voice.action    = (stack_fill == 0) ? ACT_TRIGGER : ACT_SLIDE;
         voice.reset_osc = (stack_fill == 0) ? env_idle : 1'b0;
         // full stack: shift out the oldest note
         if (stack_fill == STACK_DEPTH) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
               note_stack[i] = note_stack[i+1];
            end
            stack_fill    = STACK_DEPTH - 1;
            voice.dropped = 1'b1;
         end
         note_stack[stack_fill] = '{key: key, vel: vel, det: det};
         stack_fill++;
         voice.key = key;
         voice.vel = vel;
         voice.det = det;
      end else begin
         // remove every note with this key, keeping the order of the rest
         kept = 0;
         for (int i = 0; i < stack_fill; i++) begin
            if (note_stack[i].key != key) begin
               note_stack[kept] = note_stack[i];
               kept++;
            end
         end
         stack_fill = kept;
         if (stack_fill == 0) begin
            voice.action = ACT_RELEASE;
            voice.key    = key;
         end else begin
            voice.action = ACT_SLIDE;
            voice.key    = note_stack[stack_fill-1].key;
            voice.vel    = note_stack[stack_fill-1].vel;
            voice.det    = note_stack[stack_fill-1].det;
         end
      end
      return voice;
   endfunction

   // send one note request, with an occasional gap before it
   task automatic send_note(input field_type key, input field_type vel,
                            input field_type det, input logic env_idle);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_note_key      <= key;
      req_note_velocity <= vel;
      req_note_detune   <= det;
      req_envelope_idle <= env_idle;
      do @(posedge clock); while (req_stall);
      pending_voices.push_back(predict_voice(key, vel, det, env_idle));
      sent_items++;
   endtask

   task automatic check_field(input string label, input logic [6:0] want, input logic [6:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         failed = 1'b1;
      end
   endtask

   // compare each accepted result with the oldest predicted voice action
   always @(posedge clock) begin : check_voice
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_voices.size() == 0) begin
            $display("%0t: unexpected result action %0d key %0d", $time, rsp_voice_action,
                     rsp_target_key);
            failed = 1'b1;
         end else begin
            want = pending_voices.pop_front();
            check_field("voice_action", 7'(want.action), 7'(rsp_voice_action));
            check_field("target_key", want.key, rsp_target_key);
            check_field("target_velocity", want.vel, rsp_target_velocity);
            check_field("target_detune", want.det, rsp_target_detune);
            check_field("reset_oscillators", 7'(want.reset_osc), 7'(rsp_reset_oscillators));
            check_field("oldest_dropped", 7'(want.dropped), 7'(rsp_oldest_dropped));
         end
      end
   end

   // receiver stalls in random bursts
   always @(posedge clock) begin
      if (reset || !idle_enable) begin
         stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // release while nothing is held
   task automatic test_empty_release();
      send_note(7'd5, 7'd0, 7'd77, 1'b1);
   endtask

   // trigger with extreme fields, slide down, slide back on release, final release
   task automatic test_trigger_and_slide();
      send_note(7'd127, 7'd127, 7'd127, 1'b1);
      send_note(7'd0, 7'd1, 7'd0, 1'b1);
      send_note(7'd0, 7'd0, 7'd0, 1'b0);
      send_note(7'd127, 7'd0, 7'd127, 1'b1);
   endtask

   // same key held twice, one release drops both
   task automatic test_duplicate_keys();
      send_note(7'd42, 7'd64, 7'd85, 1'b0);
      send_note(7'd42, 7'd21, 7'd3, 1'b1);
      send_note(7'd42, 7'd0, 7'd0, 1'b0);
   endtask

   // release of a key that is not held leaves the stack alone
   task automatic test_missing_key_release();
      send_note(7'd33, 7'd99, 7'd11, 1'b0);
      send_note(7'd34, 7'd0, 7'd0, 1'b0);
   endtask

   // fill past the depth so the oldest note falls out
   task automatic test_overflow();
      for (int i = 0; i < STACK_DEPTH; i++) begin
         send_note(field_type'(100 + i), field_type'(i + 1), field_type'(127 - i), 1'b1);
      end
   endtask

   // mostly pushes and releases of held keys, with drains, floods and stray releases
   task automatic test_random_traffic(input int count);
      int pick;
      int slot;
      field_type key;
      int first;
      int n;
      first = sent_items;
      n     = 0;
      while (sent_items - first < count) begin
         if (n % 150 == 0) idle_enable = ($urandom_range(0, 3) != 0);
         if (sent_items - first >= count - TAIL_ITEMS) idle_enable = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 50 || (stack_fill == 0 && pick < 85)) begin
            // small key pool makes repeated keys common
            key = ($urandom_range(0, 3) == 0) ? field_type'($urandom_range(0, 127))
                                              : field_type'($urandom_range(60, 75));
            send_note(key, field_type'($urandom_range(1, 127)),
                      field_type'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
         end else if (pick < 85) begin
            slot = $urandom_range(0, stack_fill - 1);
            send_note(note_stack[slot].key, 7'd0, field_type'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)));
         end else if (pick < 95) begin
            send_note(field_type'($urandom_range(0, 127)), 7'd0,
                      field_type'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
         end else if (pick < 98) begin
            while (stack_fill > 0) begin
               send_note(note_stack[stack_fill-1].key, 7'd0, field_type'($urandom_range(0, 127)),
                         1'($urandom_range(0, 1)));
            end
         end else begin
            repeat (STACK_DEPTH + 2) begin
               send_note(field_type'($urandom_range(0, 127)), field_type'($urandom_range(1, 127)),
                         field_type'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            end
         end
         n++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_release();
      test_trigger_and_slide();
      test_duplicate_keys();
      test_missing_key_release();
      test_overflow();
      test_random_traffic(RANDOM_ITEMS);
      req_valid <= 1'b0;
      while (pending_voices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
